>>> rtl/two_wheel_straight_drive_sync_macros.svh
// Assertion macros for the two-wheel straight-drive block.
// Expects signals clk and rst_n in the scope of use.
`ifndef TWO_WHEEL_STRAIGHT_DRIVE_SYNC_MACROS_SVH
`define TWO_WHEEL_STRAIGHT_DRIVE_SYNC_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tws assertion failed");

// Next-cycle implication, disabled while in reset.
`define TWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tws assertion failed");

`endif

>>> rtl/tws_pkg.sv
// Shared types, constants and microcode table for the straight-drive block.
// No dependencies.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP, OP_START, OP_TCMP, OP_AVG, OP_ABS, OP_MULG, OP_TURN, OP_SPD,
    OP_MULL, OP_DIVL, OP_MULR, OP_DIVR, OP_DRIVE, OP_IDLE, OP_END_TO, OP_END_AR
  } op_t;

  // Jump conditions, tested on registered flags.
  typedef enum logic [1:0] {
    C_NONE, C_NOT_MOVING, C_TOUT, C_ARRIVE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  done;
  } ctl_t;

  typedef struct packed {
    logic moving;
    logic tout;
    logic arrive;
  } flags_t;

  typedef struct packed {
    logic [14:0] finish_count;
    logic [6:0]  nominal_pct;
    logic [7:0]  gain_q4;
    logic [15:0] timeout_ms;
    logic [15:0] pwm_period;
    logic [15:0] brake_level;
  } cfg_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TARGET  = 3'd0;
  localparam logic [2:0] CFG_BASE    = 3'd1;
  localparam logic [2:0] CFG_GAIN    = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_PERIOD  = 3'd4;
  localparam logic [2:0] CFG_BRAKE   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [14:0] RST_TARGET  = 15'd1024;
  localparam logic [6:0]  RST_BASE    = 7'd40;
  localparam logic [7:0]  RST_GAIN    = 8'd8;
  localparam logic [15:0] RST_TIMEOUT = 16'd4000;
  localparam logic [15:0] RST_PERIOD  = 16'd4199;
  localparam logic [15:0] RST_BRAKE   = 16'd4199;

  // Status codes.
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DRIVE   = 2'd1;
  localparam logic [1:0] ST_ARRIVE  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [6:0] SPEED_MIN = 7'd10;
  localparam logic [6:0] SPEED_MAX = 7'd100;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  // Branch targets.
  localparam pc_t PC_IDLE = 4'd12;
  localparam pc_t PC_TOUT = 4'd13;
  localparam pc_t PC_ARR  = 4'd14;

  function automatic ctl_t ucode(pc_t pc);
    ctl_t w;
    w = '{op: OP_NOP, cond: C_NONE, target: '0, done: 1'b1};
    case (pc)
      4'd0:  w = '{op: OP_START,  cond: C_NONE,       target: '0,      done: 1'b0};
      4'd1:  w = '{op: OP_TCMP,   cond: C_NOT_MOVING, target: PC_IDLE, done: 1'b0};
      4'd2:  w = '{op: OP_AVG,    cond: C_TOUT,       target: PC_TOUT, done: 1'b0};
      4'd3:  w = '{op: OP_ABS,    cond: C_ARRIVE,     target: PC_ARR,  done: 1'b0};
      4'd4:  w = '{op: OP_MULG,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd5:  w = '{op: OP_TURN,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd6:  w = '{op: OP_SPD,    cond: C_NONE,       target: '0,      done: 1'b0};
      4'd7:  w = '{op: OP_MULL,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd8:  w = '{op: OP_DIVL,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd9:  w = '{op: OP_MULR,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd10: w = '{op: OP_DIVR,   cond: C_NONE,       target: '0,      done: 1'b0};
      4'd11: w = '{op: OP_DRIVE,  cond: C_NONE,       target: '0,      done: 1'b1};
      4'd12: w = '{op: OP_IDLE,   cond: C_NONE,       target: '0,      done: 1'b1};
      4'd13: w = '{op: OP_END_TO, cond: C_NONE,       target: '0,      done: 1'b1};
      4'd14: w = '{op: OP_END_AR, cond: C_NONE,       target: '0,      done: 1'b1};
      default: w = '{op: OP_NOP,  cond: C_NONE,       target: '0,      done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/tws_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_seq
  import tws_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   out_block,
  input  flags_t flags,
  output logic   busy,
  output logic   step_en,
  output ctl_t   ctl
);

  logic busy_r, busy_nxt;
  pc_t  pc_r, pc_nxt;
  logic take;

  always_comb begin
    ctl     = ucode(pc_r);
    // Hold on a final step while the result slot is still occupied.
    step_en = busy_r && !(ctl.done && out_block);
    unique case (ctl.cond)
      C_NONE:       take = 1'b0;
      C_NOT_MOVING: take = !flags.moving;
      C_TOUT:       take = flags.tout;
      C_ARRIVE:     take = flags.arrive;
      default:      take = 1'b0;
    endcase
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (step_en) begin
      if (ctl.done) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = ctl.target;
      end else begin
        pc_nxt = pc_r + pc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/tws_dp.sv
// Datapath: sample registers, shared multiplier, speed clamp and result register.
// Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_dp
  import tws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               in_start_move,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic [15:0]        in_elapsed_ms,
  input  cfg_t               cfg,
  input  op_t                op,
  input  logic               step_en,
  input  logic               out_ready,
  output flags_t             flags,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_left_speed,
  output logic [6:0]         out_right_speed,
  output logic [15:0]        out_left_fwd_duty,
  output logic [15:0]        out_left_rev_duty,
  output logic [15:0]        out_right_fwd_duty,
  output logic [15:0]        out_right_rev_duty
);

  logic               start_r;
  logic signed [15:0] lc_r, rc_r;
  logic [15:0]        el_r;
  logic               moving_r, hold_r;
  logic               tout_r, arr_r;
  logic signed [16:0] sum_r, err_r;
  logic [15:0]        mag_r;
  logic               neg_r;
  logic [23:0]        prod_r;
  logic signed [20:0] turn_r;
  logic [6:0]         spd_l_r, spd_r_r;
  logic [15:0]        duty_l_r, duty_r_r;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic [6:0]         o_spd_l_r, o_spd_r_r;
  logic [15:0]        o_lf_r, o_lr_r, o_rf_r, o_rr_r;

  logic [23:0]        mul_a, mul_b;
  logic [47:0]        mul_p;
  logic signed [16:0] avg;
  logic signed [21:0] base_s, sl_raw, sr_raw;
  logic [19:0]        turn_mag;
  logic [15:0]        brk;
  logic               fin;

  function automatic logic [6:0] clamp_spd(logic signed [21:0] s);
    if (s > $signed({15'd0, SPEED_MAX})) begin
      return SPEED_MAX;
    end else if (s < $signed({15'd0, SPEED_MIN})) begin
      return SPEED_MIN;
    end
    return s[6:0];
  endfunction

  // One shared multiplier; operands chosen by the current step.
  always_comb begin
    unique case (op)
      OP_MULG: begin
        mul_a = 24'(mag_r);
        mul_b = 24'(cfg.gain_q4);
      end
      OP_MULL: begin
        mul_a = 24'(spd_l_r);
        mul_b = 24'(cfg.pwm_period);
      end
      OP_MULR: begin
        mul_a = 24'(spd_r_r);
        mul_b = 24'(cfg.pwm_period);
      end
      OP_DIVL, OP_DIVR: begin
        mul_a = prod_r;
        mul_b = RECIP_100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Average truncated toward zero.
  assign avg      = sum_r[16] ? ((sum_r + 17'sd1) >>> 1) : (sum_r >>> 1);
  assign turn_mag = prod_r[23:4];
  assign base_s   = $signed({15'd0, cfg.nominal_pct});
  assign sl_raw   = base_s - 22'(turn_r);
  assign sr_raw   = base_s + 22'(turn_r);
  assign brk      = hold_r ? cfg.brake_level : 16'd0;
  assign fin      = step_en && (op == OP_DRIVE || op == OP_IDLE ||
                                op == OP_END_TO || op == OP_END_AR);

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= in_start_move;
      lc_r    <= in_left_count;
      rc_r    <= in_right_count;
      el_r    <= in_elapsed_ms;
    end
    if (step_en) begin
      case (op)
        OP_TCMP: begin
          tout_r <= el_r > cfg.timeout_ms;
          sum_r  <= 17'(lc_r) + 17'(rc_r);
        end
        OP_AVG: begin
          arr_r <= avg >= $signed({2'b00, cfg.finish_count});
          err_r <= 17'(lc_r) - 17'(rc_r);
        end
        OP_ABS: begin
          mag_r <= err_r[16] ? 16'(-err_r) : err_r[15:0];
          neg_r <= err_r[16];
        end
        OP_MULG, OP_MULL, OP_MULR: prod_r <= mul_p[23:0];
        OP_TURN: begin
          turn_r <= neg_r ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});
        end
        OP_SPD: begin
          spd_l_r <= clamp_spd(sl_raw);
          spd_r_r <= clamp_spd(sr_raw);
        end
        OP_DIVL: duty_l_r <= mul_p[RECIP_SHIFT +: 16];
        OP_DIVR: duty_r_r <= mul_p[RECIP_SHIFT +: 16];
        OP_DRIVE: begin
          status_r  <= ST_DRIVE;
          o_spd_l_r <= spd_l_r;
          o_spd_r_r <= spd_r_r;
          o_lf_r    <= duty_l_r;
          o_lr_r    <= 16'd0;
          o_rf_r    <= duty_r_r;
          o_rr_r    <= 16'd0;
        end
        OP_IDLE: begin
          status_r  <= ST_IDLE;
          o_spd_l_r <= 7'd0;
          o_spd_r_r <= 7'd0;
          o_lf_r    <= brk;
          o_lr_r    <= brk;
          o_rf_r    <= brk;
          o_rr_r    <= brk;
        end
        OP_END_TO, OP_END_AR: begin
          status_r  <= (op == OP_END_TO) ? ST_TIMEOUT : ST_ARRIVE;
          o_spd_l_r <= 7'd0;
          o_spd_r_r <= 7'd0;
          o_lf_r    <= cfg.brake_level;
          o_lr_r    <= cfg.brake_level;
          o_rf_r    <= cfg.brake_level;
          o_rr_r    <= cfg.brake_level;
        end
        default: ;
      endcase
    end
  end

  // Move state and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r    <= 1'b0;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en && op == OP_START && start_r) begin
        moving_r <= 1'b1;
        hold_r   <= 1'b0;
      end else if (step_en && (op == OP_END_TO || op == OP_END_AR)) begin
        moving_r <= 1'b0;
        hold_r   <= 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign flags = '{moving: moving_r, tout: tout_r, arrive: arr_r};

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_left_speed     = o_spd_l_r;
  assign out_right_speed    = o_spd_r_r;
  assign out_left_fwd_duty  = o_lf_r;
  assign out_left_rev_duty  = o_lr_r;
  assign out_right_fwd_duty = o_rf_r;
  assign out_right_rev_duty = o_rr_r;

endmodule

>>> rtl/two_wheel_straight_drive_sync.sv
// Two-wheel straight-drive synchronizer, top level.
// Per sample: idle step if no move is on, else timeout end, arrival end or the full drive path.
// A new sample is taken only once the sequencer is parked again,
// and the final step stalls while the previous result waits for its transfer.
// Reset (synchronous, active low): no move, brake released, result slot empty,
// configuration registers return to their defaults. Depends on tws_pkg, tws_seq, tws_dp.
`timescale 1ns / 1ps
`include "two_wheel_straight_drive_sync_macros.svh"

module two_wheel_straight_drive_sync
  import tws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_start_move,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic [15:0]        in_elapsed_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [6:0]         out_left_speed,
  output logic [6:0]         out_right_speed,
  output logic [15:0]        out_left_fwd_duty,
  output logic [15:0]        out_left_rev_duty,
  output logic [15:0]        out_right_fwd_duty,
  output logic [15:0]        out_right_rev_duty
);

  cfg_t   cfg_r;
  logic   busy;
  logic   step_en;
  logic   in_xfer;
  logic   out_block;
  ctl_t   ctl;
  flags_t flags;
  logic   drive_ok;
  logic   stop_ok;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.finish_count <= RST_TARGET;
      cfg_r.nominal_pct  <= RST_BASE;
      cfg_r.gain_q4      <= RST_GAIN;
      cfg_r.timeout_ms   <= RST_TIMEOUT;
      cfg_r.pwm_period   <= RST_PERIOD;
      cfg_r.brake_level  <= RST_BRAKE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TARGET:  cfg_r.finish_count <= cfg_wdata[14:0];
        CFG_BASE:    cfg_r.nominal_pct  <= cfg_wdata[6:0];
        CFG_GAIN:    cfg_r.gain_q4      <= cfg_wdata[7:0];
        CFG_TIMEOUT: cfg_r.timeout_ms   <= cfg_wdata;
        CFG_PERIOD:  cfg_r.pwm_period   <= cfg_wdata;
        CFG_BRAKE:   cfg_r.brake_level  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take a new sample only when the sequencer is parked; a finished result
  // may still sit in the output register while the next sample is worked on.
  assign in_ready  = !busy;
  assign in_xfer   = in_valid && in_ready;
  // The final step waits while the previous result has not been transferred.
  assign out_block = out_valid && !out_ready;

  tws_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .out_block (out_block),
    .flags     (flags),
    .busy      (busy),
    .step_en   (step_en),
    .ctl       (ctl)
  );

  tws_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (in_xfer),
    .in_start_move      (in_start_move),
    .in_left_count      (in_left_count),
    .in_right_count     (in_right_count),
    .in_elapsed_ms      (in_elapsed_ms),
    .cfg                (cfg_r),
    .op                 (ctl.op),
    .step_en            (step_en),
    .out_ready          (out_ready),
    .flags              (flags),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_left_speed     (out_left_speed),
    .out_right_speed    (out_right_speed),
    .out_left_fwd_duty  (out_left_fwd_duty),
    .out_left_rev_duty  (out_left_rev_duty),
    .out_right_fwd_duty (out_right_fwd_duty),
    .out_right_rev_duty (out_right_rev_duty)
  );

  // Driven results carry clamped speeds and no reverse drive.
  assign drive_ok = out_left_speed >= SPEED_MIN && out_left_speed <= SPEED_MAX &&
                    out_right_speed >= SPEED_MIN && out_right_speed <= SPEED_MAX &&
                    out_left_rev_duty == 16'd0 && out_right_rev_duty == 16'd0;
  // Any other result stops the wheels with one level on all four inputs.
  assign stop_ok  = out_left_speed == 7'd0 && out_right_speed == 7'd0 &&
                    out_left_fwd_duty == out_left_rev_duty &&
                    out_right_fwd_duty == out_right_rev_duty &&
                    out_left_fwd_duty == out_right_fwd_duty;

  // A transferred sample keeps the sequencer busy on the next cycle.
  `TWS_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `TWS_ASSERT_IMP(a_drive_range, out_valid && out_status == ST_DRIVE, drive_ok)
  `TWS_ASSERT_IMP(a_stop_uniform, out_valid && out_status != ST_DRIVE, stop_ok)

endmodule
